// ===== rtl/core/amb_pkg.sv =====
// ----------------------------------------------------------------------------
// amb_pkg
// Shared types, constants and helpers of the main bus decoder.
// ----------------------------------------------------------------------------
package amb_pkg;

  // memory map
  localparam logic [15:0] ROM_TOP      = 16'hBFFF;
  localparam logic [15:0] IO_SYS       = 16'hC000;
  localparam logic [15:0] IO_P1        = 16'hC001;
  localparam logic [15:0] IO_P2        = 16'hC002;
  localparam logic [15:0] IO_DIP_A     = 16'hC003;
  localparam logic [15:0] IO_DIP_B     = 16'hC004;
  localparam logic [15:0] SND_CMD_ADDR = 16'hC800;
  localparam logic [15:0] CTRL_ADDR    = 16'hC804;
  localparam logic [15:0] SCRY_LO_ADDR = 16'hC808;
  localparam logic [15:0] SCRY_HI_ADDR = 16'hC809;
  localparam logic [15:0] SCRX_LO_ADDR = 16'hC80A;
  localparam logic [15:0] SCRX_HI_ADDR = 16'hC80B;
  localparam logic [15:0] RAM_BASE     = 16'hD000;
  localparam logic [15:0] FG_TOP       = 16'hD7FF;
  localparam logic [15:0] BG_BASE      = 16'hD800;
  localparam logic [15:0] BG_TOP       = 16'hDFFF;
  localparam logic [7:0]  OPEN_BUS     = 8'hFF;

  // work RAM geometry
  localparam int unsigned RAM_DEPTH = 12288;
  localparam int unsigned RAM_AW    = $clog2(RAM_DEPTH);

  // access kinds
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_FETCH = 2'd2;

  // configuration register indexes
  localparam logic CFG_DIP_A = 1'b0;
  localparam logic CFG_DIP_B = 1'b1;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } amb_state_t;

  // one access held between the RAM read and the write-back
  typedef struct packed {
    logic              ram_rd;
    logic              ram_wr;
    logic              tile_fg;
    logic              tile_bg;
    logic [RAM_AW-1:0] idx;
    logic [7:0]        wdata;
    logic [7:0]        rdata;
  } amb_op_t;

  // opcode bit order: out7..0 = in3,2,1,4,7,6,5,0
  function automatic logic [7:0] reorder_opcode(input logic [7:0] v);
    return {v[3], v[2], v[1], v[4], v[7], v[6], v[5], v[0]};
  endfunction

endpackage

// ===== rtl/core/amb_ram.sv =====
// ----------------------------------------------------------------------------
// amb_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module amb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/arcade_main_bus_decoder.sv =====
// ----------------------------------------------------------------------------
// arcade_main_bus_decoder
// Main CPU bus decoder: ROM, I/O, control latches and 12 KB work RAM with
// change detection on the tile RAM halves.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------------------
//  input    | in_valid / in_stall   | kind, address, write_data, rom_byte,
//           |                       | system_buttons, player_*_controls
//  output   | out_valid / out_stall | read_data, scroll, flip, sound, marks
//  config   | cfg_we                | cfg_index, cfg_data
//
// One access per cycle while in_stall is low: RAM read at the transfer edge,
// compare in the next cycle, write-back and result register load at the edge
// that ends it. out_valid rises as the access enters the output register.
// After reset a clearing pass zeroes the work RAM, in_stall high.
// A stalled output holds the pending access and stalls the input.
// ----------------------------------------------------------------------------
module arcade_main_bus_decoder (
  input  logic       clk,
  input  logic       rst,
  // configuration
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] kind,
  input  logic [15:0] address,
  input  logic [7:0] write_data,
  input  logic [7:0] rom_byte,
  input  logic [7:0] system_buttons,
  input  logic [7:0] player_one_controls,
  input  logic [7:0] player_two_controls,
  // output channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_data,
  output logic [8:0] bg_scroll_x,
  output logic [8:0] bg_scroll_y,
  output logic       screen_flipped,
  output logic       sound_held_in_reset,
  output logic [7:0] sound_latch,
  output logic       fg_tile_marked,
  output logic       bg_tile_marked
);

  import amb_pkg::*;

  amb_state_t        state, state_next;
  logic              clearing;
  logic [RAM_AW-1:0] clr_cnt;

  logic [7:0]        dip_a, dip_b;
  logic [8:0]        hscroll, vscroll;
  logic              flip, snd_reset;
  logic [7:0]        snd_cmd;

  logic              in_xfer;
  amb_op_t           op_in;
  amb_op_t           s2;
  logic              s2_valid, s2_advance;

  logic              ram_we;
  logic [RAM_AW-1:0] ram_waddr;
  logic [7:0]        ram_wdata, ram_q;

  logic              fwd_valid;
  logic [RAM_AW-1:0] fwd_idx;
  logic [7:0]        fwd_data;

  logic [7:0]        cur_byte;
  logic              changed, wb_we;
  logic [15:0]       ram_off;

  // clear / run sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == RAM_AW'(RAM_DEPTH - 1)) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: state_next = ST_RUN;
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    clearing = (state == ST_CLEAR);
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      dip_a <= 8'hFF;
      dip_b <= 8'hFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DIP_A: dip_a <= cfg_data;
        CFG_DIP_B: dip_b <= cfg_data;
        default: ;
      endcase
    end
  end

  // input handshake
  assign s2_advance = s2_valid && (!out_valid || !out_stall);
  assign in_stall   = clearing || (s2_valid && !s2_advance);
  assign in_xfer    = in_valid && !in_stall;

  // decode of the incoming access
  assign ram_off = address - RAM_BASE;

  always_comb begin
    op_in         = '0;
    op_in.idx     = ram_off[RAM_AW-1:0];
    op_in.wdata   = write_data;
    op_in.rdata   = OPEN_BUS;
    if (kind == KIND_WRITE) begin
      op_in.rdata   = 8'h00;
      op_in.ram_wr  = (address >= RAM_BASE);
      op_in.tile_fg = (address >= RAM_BASE) && (address <= FG_TOP);
      op_in.tile_bg = (address >= BG_BASE) && (address <= BG_TOP);
    end else if (kind == KIND_FETCH && address <= ROM_TOP) begin
      op_in.rdata = (address == 16'h0000) ? rom_byte : reorder_opcode(rom_byte);
    end else if (address <= ROM_TOP) begin
      op_in.rdata = rom_byte;
    end else if (address == IO_SYS) begin
      op_in.rdata = system_buttons;
    end else if (address == IO_P1) begin
      op_in.rdata = player_one_controls;
    end else if (address == IO_P2) begin
      op_in.rdata = player_two_controls;
    end else if (address == IO_DIP_A) begin
      op_in.rdata = dip_a;
    end else if (address == IO_DIP_B) begin
      op_in.rdata = dip_b;
    end else if (address >= RAM_BASE) begin
      op_in.ram_rd = 1'b1;
    end
  end

  // control latches, updated at the input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      hscroll   <= '0;
      vscroll   <= '0;
      flip      <= 1'b0;
      snd_reset <= 1'b0;
      snd_cmd   <= '0;
    end else if (in_xfer && kind == KIND_WRITE) begin
      priority if (address == SND_CMD_ADDR) begin
        snd_cmd <= write_data;
      end else if (address == CTRL_ADDR) begin
        snd_reset <= write_data[4];
        flip      <= write_data[7];
      end else if (address == SCRY_LO_ADDR) begin
        vscroll[7:0] <= write_data;
      end else if (address == SCRY_HI_ADDR) begin
        vscroll[8] <= write_data[0];
      end else if (address == SCRX_LO_ADDR) begin
        hscroll[7:0] <= write_data;
      end else if (address == SCRX_HI_ADDR) begin
        hscroll[8] <= write_data[0];
      end else begin
      end
    end
  end

  // access stage between RAM read and write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (in_xfer) begin
      s2_valid <= 1'b1;
    end else if (s2_advance) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s2 <= op_in;
    end
  end

  // forward the write that lands at the same edge as the read
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (in_xfer) begin
      fwd_valid <= ram_we;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      fwd_idx  <= ram_waddr;
      fwd_data <= ram_wdata;
    end
  end

  // compare and write-back
  assign cur_byte = (fwd_valid && fwd_idx == s2.idx) ? fwd_data : ram_q;
  assign changed  = (cur_byte != s2.wdata);
  assign wb_we    = s2_advance && s2.ram_wr &&
                    (changed || !(s2.tile_fg || s2.tile_bg));

  assign ram_we    = clearing || wb_we;
  assign ram_waddr = clearing ? clr_cnt : s2.idx;
  assign ram_wdata = clearing ? 8'h00 : s2.wdata;

  amb_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_work_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_xfer),
    .raddr (op_in.idx),
    .rdata (ram_q)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_advance) begin
      read_data           <= s2.ram_rd ? cur_byte : s2.rdata;
      bg_scroll_x         <= hscroll;
      bg_scroll_y         <= vscroll;
      screen_flipped      <= flip;
      sound_held_in_reset <= snd_reset;
      sound_latch         <= snd_cmd;
      fg_tile_marked      <= s2.tile_fg && changed;
      bg_tile_marked      <= s2.tile_bg && changed;
    end
  end

`ifndef SYNTH
  // no transfer is taken while the RAM is being cleared
  a_no_xfer_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !in_xfer)
    else $error("input transfer during clearing pass");

  // an accepted access reaches the write-back stage next cycle
  a_xfer_fills_s2: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> s2_valid)
    else $error("accepted access lost before write-back");

  // RAM writes come only from the clearing pass or a retiring access
  a_ram_we_source: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (clearing || (s2_valid && s2_advance && s2.ram_wr)))
    else $error("unexpected work RAM write");

  // a result never marks both tile halves
  a_marks_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(fg_tile_marked && bg_tile_marked))
    else $error("both tile marks set");

  // a retiring access always finds the output register free
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    s2_advance |-> (!out_valid || !out_stall))
    else $error("output overwritten while stalled");
`endif

endmodule
